@@ rtl/string_to_integer_parser_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication.
`define STP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stp assertion failed");

// Next-cycle implication.
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stp assertion failed");

`endif

@@ rtl/stp_pkg.sv @@
package stp_pkg;

	localparam int DEFAULT_MAX_LENGTH = 4096;
	localparam int BASE_W             = 6;
	localparam int MODE_W             = 2;
	localparam int OFFSET_W           = 12;
	localparam int VALUE_W            = 64;
	localparam int CFG_INDEX_W        = 4;
	localparam int CFG_DATA_W         = 8;
	localparam int IN_TDATA_W         = 8;
	localparam int OUT_TDATA_W        = 80;

	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_MODE = 4'd1;

	localparam logic [MODE_W-1:0] MODE_U64 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_S64 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_S32 = 2'd2;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_WIDE  = 6'd32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] DIGIT_NONE = 8'hFF;

	typedef enum logic [4:0] {
		PH_SKIP   = 5'b00001,
		PH_SIGN   = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  acc;
		logic                negative;
		logic                overflowed;
		logic [OFFSET_W-1:0] offset;
	} fin_t;

endpackage

@@ rtl/string_to_integer_parser.sv @@
// String to integer parser.
// Input stream (s_*): one character per item in s_tdata[7:0]; a string ends
// at a NUL character or at an item with s_tlast high, and that closing item
// yields exactly one result. Other items yield none.
// Output stream (m_*): m_tdata[63:0] value, [75:64] end offset,
// [76] range error, upper bits zero.
// Configuration (cfg_*): index 0 number base, index 1 result mode; write
// only while no string is in flight. cfg_ready is always high.
// Throughput: one character per cycle, except that a closing item waits
// while the finishing stage is full; the accumulator update is combinational.
// Path: the closing item passes the input register, then the finishing
// register, then the output register.
// Stalls: a held m_tready parks the result in the output register; one more
// result waits in the finishing stage, after which s_tready drops only when
// a further closing item arrives.
// Reset: all stages empty, parser at the start of a string, number base 10,
// result mode signed 32.
module string_to_integer_parser
	import stp_pkg::*;
#(
	parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] character
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [63:0] value, [75:64] end_offset, [76] range_error
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [BASE_W-1:0] number_base_q;
	logic [MODE_W-1:0] result_mode_q;
	logic              fin_valid, fin_ready;
	fin_t              fin;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
			result_mode_q <= MODE_S32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUMBER_BASE: number_base_q <= cfg_data[BASE_W-1:0];
				CFG_RESULT_MODE: result_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	stp_scan #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.number_base(number_base_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.fin_ready  (fin_ready),
		.fin_valid  (fin_valid),
		.fin        (fin)
	);

	stp_shape u_shape (
		.clk        (clk),
		.arst_n     (arst_n),
		.result_mode(result_mode_q),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.fin        (fin),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

@@ rtl/stp_scan.sv @@
module stp_scan
	import stp_pkg::*;
#(
	parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BASE_W-1:0]     number_base,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] character
	input  logic                  s_tlast,
	input  logic                  fin_ready,
	output logic                  fin_valid,
	output fin_t                  fin
);

	localparam int CAP_INT = (MAX_LENGTH - 1 < 4095) ? MAX_LENGTH - 1 : 4095;
	localparam logic [OFFSET_W-1:0] CAP = OFFSET_W'(CAP_INT);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	phase_t              phase_q, phase_d;
	logic [VALUE_W-1:0]  acc_q, acc_d;
	logic                neg_q, neg_d;
	logic [BASE_W-1:0]   ebase_q, ebase_d;
	logic [OFFSET_W-1:0] pos_q, pos_d;
	logic [OFFSET_W-1:0] stop_q, stop_d;
	logic                ovf_q, ovf_d;

	logic       is_ws, is_sign, is_x, x_ok;
	logic [7:0] dval;
	logic       produce, step;

	assign is_ws   = ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR)) || (char_s1 == CH_SPACE);
	assign is_sign = (char_s1 == CH_PLUS) || (char_s1 == CH_MINUS);
	assign is_x    = (char_s1 == CH_LX) || (char_s1 == CH_UX);
	assign x_ok    = (number_base == '0) || (number_base == BASE_HEX) || (number_base > BASE_WIDE);

	always_comb begin
		if ((char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE)) begin
			dval = char_s1 - CH_ZERO;
		end else if ((char_s1 >= CH_LA) && (char_s1 <= CH_LZ)) begin
			dval = char_s1 - CH_LA + 8'd10;
		end else if ((char_s1 >= CH_UA) && (char_s1 <= CH_UZ)) begin
			dval = char_s1 - CH_UA + 8'd10;
		end else begin
			dval = DIGIT_NONE;
		end
	end

	always_comb begin
		logic              lead;
		logic              digit_go;
		logic              adv;
		logic [BASE_W-1:0] dbase;
		logic [69:0]       prod;

		phase_d  = phase_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		ebase_d  = ebase_q;
		pos_d    = pos_q;
		stop_d   = stop_q;
		ovf_d    = ovf_q;
		lead     = 1'b0;
		digit_go = 1'b0;
		adv      = 1'b0;
		dbase    = ebase_q;

		if (char_s1 != CH_NUL) begin
			case (phase_q)
				PH_SKIP: begin
					if (is_ws) begin
						adv = 1'b1;
					end else if (is_sign) begin
						phase_d = PH_SIGN;
						neg_d   = (char_s1 == CH_MINUS);
						adv     = 1'b1;
					end else begin
						lead = 1'b1;
					end
				end
				PH_SIGN: begin
					lead = 1'b1;
				end
				PH_ZERO: begin
					if (is_x) begin
						if (x_ok) begin
							ebase_d = (number_base == '0) ? BASE_HEX : number_base;
							phase_d = PH_DIGITS;
							adv     = 1'b1;
						end else begin
							stop_d  = pos_q;
							phase_d = PH_DONE;
						end
					end else begin
						dbase    = (number_base == '0) ? BASE_OCT : number_base;
						ebase_d  = dbase;
						phase_d  = PH_DIGITS;
						digit_go = 1'b1;
					end
				end
				PH_DIGITS: begin
					digit_go = 1'b1;
				end
				default: ;
			endcase

			if (lead) begin
				if (char_s1 == CH_ZERO) begin
					phase_d = PH_ZERO;
					adv     = 1'b1;
				end else begin
					dbase    = (number_base == '0) ? BASE_DEC : number_base;
					ebase_d  = dbase;
					phase_d  = PH_DIGITS;
					digit_go = 1'b1;
				end
			end
		end

		prod = 70'(acc_q) * 70'(dbase) + 70'(dval);

		if (digit_go) begin
			if ((dbase == '0) || (dval >= {2'b00, dbase})) begin
				stop_d  = pos_q;
				phase_d = PH_DONE;
			end else if (prod[69:64] != '0) begin
				ovf_d   = 1'b1;
				acc_d   = '1;
				stop_d  = pos_q;
				phase_d = PH_DONE;
			end else begin
				acc_d = prod[63:0];
				adv   = 1'b1;
			end
		end

		if (adv && (pos_q < CAP)) begin
			pos_d = pos_q + 1'b1;
		end
	end

	assign produce   = valid_s1 && ((char_s1 == CH_NUL) || last_s1);
	assign step      = valid_s1 && (!produce || fin_ready);
	assign s_tready  = !valid_s1 || step;
	assign fin_valid = produce;

	always_comb begin
		fin.acc        = acc_d;
		fin.negative   = neg_d;
		fin.overflowed = ovf_d;
		if (phase_d == PH_SKIP) begin
			fin.offset = '0;
		end else if (phase_d == PH_DONE) begin
			fin.offset = stop_d;
		end else begin
			fin.offset = pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			ebase_q <= '0;
			pos_q   <= '0;
			stop_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (produce) begin
				phase_q <= PH_SKIP;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				ebase_q <= '0;
				pos_q   <= '0;
				stop_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				ebase_q <= ebase_d;
				pos_q   <= pos_d;
				stop_q  <= stop_d;
				ovf_q   <= ovf_d;
			end
		end
	end

endmodule

@@ rtl/stp_shape.sv @@
module stp_shape
	import stp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MODE_W-1:0]      result_mode,
	input  logic                   fin_valid,
	output logic                   fin_ready,
	input  fin_t                   fin,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [63:0] value, [75:64] end_offset, [76] range_error
);

	localparam logic [VALUE_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [VALUE_W-1:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
	localparam logic [VALUE_W-1:0] S32_MAG = 64'h0000_0000_8000_0000;
	localparam logic [VALUE_W-1:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;

	logic valid_s2;
	fin_t fin_s2;

	logic                m_valid_q;
	logic [VALUE_W-1:0]  value_q, value_d;
	logic [OFFSET_W-1:0] off_q;
	logic                rng_q, rng_d;
	logic                out_free;
	logic [VALUE_W-1:0]  neg_val;

	assign out_free  = !m_valid_q || m_tready;
	assign fin_ready = !valid_s2 || out_free;
	assign neg_val   = '0 - fin_s2.acc;

	always_comb begin
		value_d = fin_s2.acc;
		rng_d   = fin_s2.overflowed;
		case (result_mode)
			MODE_U64: begin
				value_d = fin_s2.acc;
			end
			MODE_S64: begin
				if (!fin_s2.negative) begin
					if (fin_s2.acc > S64_MAX) begin
						value_d = S64_MAX;
						rng_d   = 1'b1;
					end
				end else if (fin_s2.acc > S64_MIN) begin
					value_d = S64_MIN;
					rng_d   = 1'b1;
				end else begin
					value_d = neg_val;
				end
			end
			default: begin
				if (!fin_s2.negative) begin
					if (fin_s2.acc > S32_MAX) begin
						value_d = S32_MAX;
						rng_d   = 1'b1;
					end
				end else if (fin_s2.acc > S32_MAG) begin
					value_d = S32_MIN;
					rng_d   = 1'b1;
				end else begin
					value_d = neg_val;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (fin_ready) begin
				valid_s2 <= fin_valid;
			end
			if (out_free) begin
				m_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			fin_s2 <= fin;
		end
		if (valid_s2 && out_free) begin
			value_q <= value_d;
			off_q   <= fin_s2.offset;
			rng_q   <= rng_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, rng_q, off_q, value_q};

endmodule

@@ rtl/stp_checker.sv @@
`include "string_to_integer_parser_macros.svh"

module stp_checker
	import stp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata    // [63:0] value, [75:64] end_offset, [76] range_error
);

	// Hold a stalled result.
	`STP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// An empty output side drains every stage, so input is open.
	`STP_ASSERT_NOW(a_in_open, clk, arst_n, !m_tvalid, s_tready)
	// Saturated results are never zero.
	`STP_ASSERT_NOW(a_sat_nonzero, clk, arst_n, m_tvalid && m_tdata[76], m_tdata[63:0] != '0)
	// Padding stays clear.
	`STP_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[79:77] == 3'b000)

endmodule

bind string_to_integer_parser stp_checker u_stp_checker (.*);
